>>> rtl/core/bba_pkg.sv
// shared types, constants and widths of the buddy block allocator
`default_nettype none
package bba_pkg;

    localparam int MAX_DEPTH = 10;
    localparam int SLOTS     = 1 << MAX_DEPTH;
    localparam int SLOT_W    = MAX_DEPTH;
    localparam int LINK_W    = MAX_DEPTH + 1;
    localparam int ORD_W     = $clog2(MAX_DEPTH + 1);
    localparam int SCALE_W   = 5;
    localparam int BYTE_W    = 34;
    localparam int SZ_W      = (1 << SCALE_W) + MAX_DEPTH;
    localparam int INFO_W    = ORD_W + 2;

    localparam logic [LINK_W-1:0] END_MARK = LINK_W'(SLOTS);
    localparam logic [ORD_W-1:0]  TOP_ORD  = ORD_W'(MAX_DEPTH);
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(8);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD_ADDR = 2'd2,
        ST_NOT_BUSY = 2'd3
    } status_t;

    // per slot bookkeeping word
    typedef struct packed {
        logic             busy;
        logic             free_head;
        logic [ORD_W-1:0] order;
    } slot_info_t;

    // byte / slot conversion results
    typedef struct packed {
        logic [BYTE_W-1:0] offset;
        logic [SLOT_W-1:0] index;
        logic              bad;
    } scale_res_t;

endpackage
`default_nettype wire

>>> rtl/core/buddy_block_allocator_core.sv
// top level of the buddy block allocator: sequencer, free list heads and slot tables
//
// channel | signals                                  | direction
// --------+------------------------------------------+----------
// cfg     | cfg_valid cfg_ready cfg_data             | in
// in      | in_valid in_ready mode request_size      | in
//         | release_offset                           |
// out     | out_valid out_ready block_offset status  | out
//         | all_free                                 |
//
// one transaction at a time: an allocate searches upward through the orders, splits the found
// block down to the fitting order and pops it; a release checks the offset and the busy bit,
// merges with free buddies (walking a free list to unlink one) and pushes the result; in_ready
// returns in the same cycle that out_valid is loaded
// after reset a clearing pass over all 1024 slots initializes the link and slot rams with in_ready
// low; cfg writes are taken at any time; a waiting result stalls only the next completion
`default_nettype none
module buddy_block_allocator_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [bba_pkg::SCALE_W-1:0] cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        mode,
    input  wire logic [bba_pkg::BYTE_W-1:0]  request_size,
    input  wire logic [bba_pkg::BYTE_W-1:0]  release_offset,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [bba_pkg::BYTE_W-1:0]  block_offset,
    output logic      [1:0]                  status,
    output logic                             all_free
);
    import bba_pkg::*;

    typedef enum logic [17:0] {
        S_CLEAR      = 18'b000000000000000001,
        S_IDLE       = 18'b000000000000000010,
        S_A_SEARCH   = 18'b000000000000000100,
        S_A_SPLIT_RD = 18'b000000000000001000,
        S_A_SPLIT_LO = 18'b000000000000010000,
        S_A_SPLIT_HI = 18'b000000000000100000,
        S_A_POP_RD   = 18'b000000000001000000,
        S_A_POP_WR   = 18'b000000000010000000,
        S_R_CHECK    = 18'b000000000100000000,
        S_R_BUSY     = 18'b000000001000000000,
        S_R_MERGE    = 18'b000000010000000000,
        S_R_MCHK     = 18'b000000100000000000,
        S_R_WALK_RD  = 18'b000001000000000000,
        S_R_WALK_CHK = 18'b000010000000000000,
        S_R_UNLINKED = 18'b000100000000000000,
        S_R_PUSH     = 18'b001000000000000000,
        S_DONE       = 18'b010000000000000000,
        S_SPARE      = 18'b100000000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [SCALE_W-1:0] scale_reg, scale_next;

    // free list heads, one per order
    logic [LINK_W-1:0] head_reg  [0:MAX_DEPTH];
    logic [LINK_W-1:0] head_next [0:MAX_DEPTH];

    // working registers of the sequencer
    logic [SLOT_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              mode_reg, mode_next;
    logic [BYTE_W-1:0] req_reg, req_next;
    logic [BYTE_W-1:0] roff_reg, roff_next;
    logic [ORD_W-1:0]  d_reg, d_next;
    logic [SZ_W-1:0]   sz_reg, sz_next;
    logic [SLOT_W-1:0] loc_reg, loc_next;
    logic [SLOT_W-1:0] bud_reg, bud_next;
    logic [LINK_W-1:0] budnx_reg, budnx_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] steps_reg, steps_next;
    logic [BYTE_W-1:0] res_off_reg, res_off_next;
    status_t           res_st_reg, res_st_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_off_reg, out_off_next;
    logic [1:0]        out_st_reg, out_st_next;
    logic              out_free_reg, out_free_next;

    // ram ports
    logic              link_we;
    logic [SLOT_W-1:0] link_waddr, link_raddr;
    logic [LINK_W-1:0] link_wdata, link_rdata;
    logic              slot_we;
    logic [SLOT_W-1:0] slot_waddr, slot_raddr;
    logic [INFO_W-1:0] slot_wdata, slot_rdata;
    slot_info_t        slot_wr, slot_rd;

    logic [SLOT_W-1:0] scale_slot;
    scale_res_t        scale_res;

    logic [ORD_W-1:0]  d_m1;
    logic [LINK_W-1:0] head_d, head_dm1;
    logic [SZ_W-1:0]   req_ext;
    logic              too_small, search_more, split_go;
    logic [SLOT_W-1:0] bit_d, bit_dm1, bud_cur;

    bba_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    bba_ram #(.WIDTH(INFO_W), .DEPTH(SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    bba_scale u_scale (
        .scale    (scale_reg),
        .slot     (scale_slot),
        .byte_off (roff_reg),
        .res      (scale_res)
    );

    assign slot_rd    = slot_info_t'(slot_rdata);
    assign slot_wdata = INFO_W'(slot_wr);

    always_comb
    begin
        d_m1        = d_reg - ORD_W'(1);
        head_d      = head_reg[d_reg];
        head_dm1    = head_reg[d_m1];
        req_ext     = SZ_W'(req_reg);
        too_small   = (sz_reg < req_ext) || (head_d == END_MARK);
        search_more = (d_reg < TOP_ORD) && too_small;
        split_go    = (d_reg != '0) && ((sz_reg >> 1) >= req_ext);
        bit_d       = SLOT_W'(1) << d_reg;
        bit_dm1     = SLOT_W'(1) << d_m1;
        bud_cur     = loc_reg ^ bit_d;
    end

    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign block_offset = out_off_reg;
    assign status       = out_st_reg;
    assign all_free     = out_free_reg;

    always_comb
    begin
        state_next   = state_reg;
        scale_next   = scale_reg;
        head_next    = head_reg;
        clr_cnt_next = clr_cnt_reg;
        mode_next    = mode_reg;
        req_next     = req_reg;
        roff_next    = roff_reg;
        d_next       = d_reg;
        sz_next      = sz_reg;
        loc_next     = loc_reg;
        bud_next     = bud_reg;
        budnx_next   = budnx_reg;
        cur_next     = cur_reg;
        steps_next   = steps_reg;
        res_off_next = res_off_reg;
        res_st_next  = res_st_reg;

        out_valid_next = out_valid_reg;
        out_off_next   = out_off_reg;
        out_st_next    = out_st_reg;
        out_free_next  = out_free_reg;

        link_we    = 1'b0;
        link_waddr = loc_reg;
        link_wdata = END_MARK;
        link_raddr = loc_reg;
        slot_we    = 1'b0;
        slot_waddr = loc_reg;
        slot_wr    = '0;
        slot_raddr = loc_reg;
        scale_slot = loc_reg;

        if (cfg_valid && cfg_ready)
        begin
            scale_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                link_we    = 1'b1;
                link_waddr = clr_cnt_reg;
                link_wdata = END_MARK;
                slot_we    = 1'b1;
                slot_waddr = clr_cnt_reg;
                if (clr_cnt_reg == '0)
                begin
                    slot_wr.free_head = 1'b1;
                    slot_wr.order     = TOP_ORD;
                end
                clr_cnt_next = clr_cnt_reg + SLOT_W'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next    = mode;
                    req_next     = request_size;
                    roff_next    = release_offset;
                    d_next       = '0;
                    sz_next      = SZ_W'(1) << scale_reg;
                    res_off_next = '0;
                    state_next   = mode ? S_R_CHECK : S_A_SEARCH;
                end
            end

            // walk up the orders until one fits and has a free block; no space when the top order fails
            S_A_SEARCH:
            begin
                if (search_more)
                begin
                    d_next  = d_reg + ORD_W'(1);
                    sz_next = sz_reg << 1;
                end
                else if (too_small)
                begin
                    res_st_next = ST_NO_SPACE;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = split_go ? S_A_SPLIT_RD : S_A_POP_RD;
                end
            end

            S_A_SPLIT_RD:
            begin
                loc_next   = head_d[SLOT_W-1:0];
                link_raddr = head_d[SLOT_W-1:0];
                state_next = S_A_SPLIT_LO;
            end

            // pop the block, push the upper half one order down
            S_A_SPLIT_LO:
            begin
                head_next[d_reg]  = link_rdata;
                link_we           = 1'b1;
                link_waddr        = loc_reg ^ bit_dm1;
                link_wdata        = head_dm1;
                slot_we           = 1'b1;
                slot_waddr        = loc_reg ^ bit_dm1;
                slot_wr.free_head = 1'b1;
                slot_wr.order     = d_m1;
                d_next            = d_m1;
                sz_next           = sz_reg >> 1;
                state_next        = S_A_SPLIT_HI;
            end

            // then the lower half in front of it
            S_A_SPLIT_HI:
            begin
                head_next[d_reg]  = LINK_W'(loc_reg);
                link_we           = 1'b1;
                link_waddr        = loc_reg;
                link_wdata        = LINK_W'(bud_cur);
                slot_we           = 1'b1;
                slot_waddr        = loc_reg;
                slot_wr.free_head = 1'b1;
                slot_wr.order     = d_reg;
                state_next        = split_go ? S_A_SPLIT_RD : S_A_POP_RD;
            end

            S_A_POP_RD:
            begin
                loc_next   = head_d[SLOT_W-1:0];
                link_raddr = head_d[SLOT_W-1:0];
                state_next = S_A_POP_WR;
            end

            S_A_POP_WR:
            begin
                head_next[d_reg] = link_rdata;
                link_we          = 1'b1;
                link_waddr       = loc_reg;
                link_wdata       = END_MARK;
                slot_we          = 1'b1;
                slot_waddr       = loc_reg;
                slot_wr.busy     = 1'b1;
                slot_wr.order    = d_reg;
                res_off_next     = scale_res.offset;
                res_st_next      = ST_OK;
                state_next       = S_DONE;
            end

            S_R_CHECK:
            begin
                if (scale_res.bad)
                begin
                    res_st_next = ST_BAD_ADDR;
                    state_next  = S_DONE;
                end
                else
                begin
                    loc_next   = scale_res.index;
                    slot_raddr = scale_res.index;
                    state_next = S_R_BUSY;
                end
            end

            S_R_BUSY:
            begin
                if (!slot_rd.busy)
                begin
                    res_st_next = ST_NOT_BUSY;
                    state_next  = S_DONE;
                end
                else
                begin
                    slot_we       = 1'b1;
                    slot_waddr    = loc_reg;
                    slot_wr.order = slot_rd.order;
                    d_next        = (slot_rd.order > TOP_ORD) ? TOP_ORD : slot_rd.order;
                    state_next    = S_R_MERGE;
                end
            end

            S_R_MERGE:
            begin
                if (d_reg < TOP_ORD)
                begin
                    bud_next   = bud_cur;
                    slot_raddr = bud_cur;
                    link_raddr = bud_cur;
                    state_next = S_R_MCHK;
                end
                else
                begin
                    state_next = S_R_PUSH;
                end
            end

            // buddy must start a free block of the same order
            S_R_MCHK:
            begin
                if (!slot_rd.free_head || (slot_rd.order != d_reg))
                begin
                    state_next = S_R_PUSH;
                end
                else
                begin
                    budnx_next = link_rdata;
                    if (head_d == LINK_W'(bud_reg))
                    begin
                        head_next[d_reg] = link_rdata;
                        state_next       = S_R_UNLINKED;
                    end
                    else
                    begin
                        cur_next   = head_d;
                        steps_next = '0;
                        state_next = S_R_WALK_RD;
                    end
                end
            end

            S_R_WALK_RD:
            begin
                link_raddr = cur_reg[SLOT_W-1:0];
                if ((steps_reg < LINK_W'(SLOTS)) && (cur_reg != END_MARK))
                begin
                    state_next = S_R_WALK_CHK;
                end
                else
                begin
                    state_next = S_R_UNLINKED;
                end
            end

            S_R_WALK_CHK:
            begin
                if (link_rdata == LINK_W'(bud_reg))
                begin
                    link_we    = 1'b1;
                    link_waddr = cur_reg[SLOT_W-1:0];
                    link_wdata = budnx_reg;
                    state_next = S_R_UNLINKED;
                end
                else
                begin
                    cur_next   = link_rdata;
                    steps_next = steps_reg + LINK_W'(1);
                    state_next = S_R_WALK_RD;
                end
            end

            S_R_UNLINKED:
            begin
                link_we       = 1'b1;
                link_waddr    = bud_reg;
                link_wdata    = END_MARK;
                slot_we       = 1'b1;
                slot_waddr    = bud_reg;
                slot_wr.order = d_reg;
                loc_next      = loc_reg & ~bit_d;
                d_next        = d_reg + ORD_W'(1);
                state_next    = S_R_MERGE;
            end

            S_R_PUSH:
            begin
                head_next[d_reg]  = LINK_W'(loc_reg);
                link_we           = 1'b1;
                link_waddr        = loc_reg;
                link_wdata        = head_d;
                slot_we           = 1'b1;
                slot_waddr        = loc_reg;
                slot_wr.free_head = 1'b1;
                slot_wr.order     = d_reg;
                res_st_next       = ST_OK;
                state_next        = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_off_next   = res_off_reg;
                    out_st_next    = res_st_reg;
                    out_free_next  = (head_reg[MAX_DEPTH] == '0);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            scale_reg     <= SCALE_RESET;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= MAX_DEPTH; i++)
            begin
                head_reg[i] <= (i == MAX_DEPTH) ? '0 : END_MARK;
            end
        end
        else
        begin
            state_reg     <= state_next;
            scale_reg     <= scale_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        req_reg      <= req_next;
        roff_reg     <= roff_next;
        d_reg        <= d_next;
        sz_reg       <= sz_next;
        loc_reg      <= loc_next;
        bud_reg      <= bud_next;
        budnx_reg    <= budnx_next;
        cur_reg      <= cur_next;
        steps_reg    <= steps_next;
        res_off_reg  <= res_off_next;
        res_st_reg   <= res_st_next;
        out_off_reg  <= out_off_next;
        out_st_reg   <= out_st_next;
        out_free_reg <= out_free_next;
    end

endmodule
`default_nettype wire

>>> rtl/core/bba_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/core/bba_scale.sv
// shift unit converting between slot index and byte offset
`default_nettype none
module bba_scale (
    input  wire logic [bba_pkg::SCALE_W-1:0] scale,
    input  wire logic [bba_pkg::SLOT_W-1:0]  slot,
    input  wire logic [bba_pkg::BYTE_W-1:0]  byte_off,
    output bba_pkg::scale_res_t              res
);
    import bba_pkg::*;

    logic [BYTE_W-1:0] unit_mask;
    logic [BYTE_W-1:0] idx_full;

    always_comb
    begin
        unit_mask  = (BYTE_W'(1) << scale) - BYTE_W'(1);
        idx_full   = byte_off >> scale;
        res.offset = BYTE_W'(slot) << scale;
        res.index  = idx_full[SLOT_W-1:0];
        // misaligned, or past the last slot
        res.bad    = ((byte_off & unit_mask) != '0) || (idx_full >= BYTE_W'(SLOTS));
    end

endmodule
`default_nettype wire
